/* sv/cisf_pkg.sv */
// ----------------------------------------------------------------------------
// cisf_pkg: shared types and codes for the CAN id subscription filter
// Request and status codes, the queue entry between front and back, and
// the per-slot filter record.
// ----------------------------------------------------------------------------
`default_nettype none
package cisf_pkg;

	localparam int IdW = 29;
	localparam int SubW = 16;
	localparam int MaxResults = 16;

	// request codes
	localparam logic [1:0] REQ_SUB = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_UNSUB = 2'd2;
	localparam logic [1:0] REQ_FRAME = 2'd3;

	// filter kinds
	localparam logic [1:0] KIND_RANGE = 2'd0;
	localparam logic [1:0] KIND_MASK = 2'd1;
	localparam logic [1:0] KIND_LIST = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	// classified operation
	typedef enum logic [2:0] {
		OP_SUB,
		OP_BAD_KIND,
		OP_APPEND,
		OP_UNSUB,
		OP_BAD_TARGET,
		OP_FRAME
	} op_t;

	// one request in the queue
	typedef struct packed {
		logic            vld;
		op_t             op;
		logic [1:0]      kind;
		logic [IdW-1:0]  a;
		logic [IdW-1:0]  b;
	} q_entry_t;

	// one subscription slot
	typedef struct packed {
		logic [1:0]      kind;
		logic [IdW-1:0]  low;
		logic [IdW-1:0]  high;
		logic [SubW-1:0] ident;
	} slot_t;

endpackage
`default_nettype wire

/* sv/can_id_subscription_filter.sv */
// ----------------------------------------------------------------------------
// can_id_subscription_filter: CAN receive subscription table
// Range, mask and id-list acceptance filters with subscribe, append,
// unsubscribe and frame lookup requests.
//
//   channel   handshake              payload
//   request   start / busy           req_type filter_kind word_a word_b
//                                    target_sub frame_id
//   result    result_valid (strobe)  status is_delivery sub_number last
//
// Subscribe, bad and no-target append requests give their result from
// idle on leaving the queue; append passes a read wait and a write state.
// Unsubscribe takes a read wait and a check per slot scanned. A frame
// takes the same per slot and per list entry checked, a start state for
// the report, then a pass over all slots per delivery (single read port).
// Two requests queue ahead of the executor; busy rises when both are held.
// Reset empties the table; result ports cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module can_id_subscription_filter import cisf_pkg::*; #(
	parameter int SUBS = 16,
	parameter int LIST_MAX = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [1:0]      req_type,
	input  wire logic [1:0]      filter_kind,
	input  wire logic [IdW-1:0]  word_a,
	input  wire logic [IdW-1:0]  word_b,
	input  wire logic [SubW-1:0] target_sub,
	input  wire logic [IdW-1:0]  frame_id,
	output logic                 result_valid,
	output logic [1:0]           status,
	output logic                 is_delivery,
	output logic [SubW-1:0]      sub_number,
	output logic                 last
);

	q_entry_t head;
	logic     pop;

	cisf_front u_front (
		.clk, .arst_n, .start, .busy, .req_type, .filter_kind,
		.word_a, .word_b, .target_sub, .frame_id, .pop, .head
	);

	cisf_back #(.SUBS(SUBS), .LIST_MAX(LIST_MAX)) u_back (
		.clk, .arst_n, .head, .pop, .result_valid, .status,
		.is_delivery, .sub_number, .last
	);

	// deliveries always carry ok status and a nonzero id
	a_del_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_delivery |-> status == ST_OK && sub_number != '0)
		else $error("delivery with bad status or id");

	// a non-delivery result is always the final one
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_delivery |-> last)
		else $error("non-delivery result not marked last");

	// the queue is only popped when it holds a request
	a_pop_vld: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.vld)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

/* sv/cisf_front.sv */
// ----------------------------------------------------------------------------
// cisf_front: request intake
// Classifies each request into an operation and holds it in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module cisf_front import cisf_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire logic [1:0]      req_type,
	input  wire logic [1:0]      filter_kind,
	input  wire logic [IdW-1:0]  word_a,
	input  wire logic [IdW-1:0]  word_b,
	input  wire logic [SubW-1:0] target_sub,
	input  wire logic [IdW-1:0]  frame_id,
	input  wire logic            pop,
	output q_entry_t             head
);

	q_entry_t ent_q [2];
	logic     wr_q, rd_q;
	logic [1:0] cnt_q;
	q_entry_t cls;
	logic     push;

	// classify request
	always_comb begin
		cls = '0;
		cls.vld = 1'b1;
		cls.kind = filter_kind;
		cls.a = word_a;
		cls.b = word_b;
		case (req_type)
			REQ_SUB: cls.op = (filter_kind == 2'd3) ? OP_BAD_KIND : OP_SUB;
			REQ_APPEND: cls.op = OP_APPEND;
			REQ_UNSUB: begin
				cls.op = (target_sub == '0) ? OP_BAD_TARGET : OP_UNSUB;
				cls.a = IdW'(target_sub);
			end
			REQ_FRAME: begin
				cls.op = OP_FRAME;
				cls.a = frame_id;
			end
			default: cls.op = OP_BAD_KIND;
		endcase
	end

	assign busy = (cnt_q == 2'd2);
	assign push = start && !busy;

	always_comb begin
		head = ent_q[rd_q];
		head.vld = (cnt_q != 2'd0);
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) ent_q[wr_q] <= cls;
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

/* sv/cisf_back.sv */
// ----------------------------------------------------------------------------
// cisf_back: request execution
// Holds the slot table and list store, runs one queued request at a time
// and drives the registered result ports.
// ----------------------------------------------------------------------------
`default_nettype none
module cisf_back import cisf_pkg::*; #(
	parameter int SUBS = 16,
	parameter int LIST_MAX = 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  var  q_entry_t        head,
	output logic                 pop,
	output logic                 result_valid,
	output logic [1:0]           status,
	output logic                 is_delivery,
	output logic [SubW-1:0]      sub_number,
	output logic                 last
);

	localparam int SW = (SUBS > 1) ? $clog2(SUBS) : 1;
	localparam int CW = $clog2(LIST_MAX + 1);
	localparam int JW = (LIST_MAX > 1) ? $clog2(LIST_MAX) : 1;
	localparam int LAW = (SUBS * LIST_MAX > 1) ? $clog2(SUBS * LIST_MAX) : 1;
	localparam int NW = $clog2(SUBS + MaxResults + 1);
	localparam int LD = SUBS * LIST_MAX;

	typedef enum logic [3:0] {
		S_IDLE, S_APP_WAIT, S_APP_DO, S_UN_WAIT, S_UN_CHK,
		S_M_WAIT, S_M_CHK, S_L_WAIT, S_L_CHK, S_SEL0, S_S_WAIT, S_S_CHK
	} state_t;

	state_t         state_q;
	q_entry_t       cur_q;
	logic [SUBS-1:0] valid_q, match_q;
	logic [SubW-1:0] id_q, best_q, bound_q;
	logic [SW:0]    newest_q;
	logic [SW-1:0]  ptr_q;
	logic [JW-1:0]  j_q;
	logic [NW-1:0]  total_q, sent_q, lim;
	logic           first_q;

	// memories
	slot_t          slot_mem [SUBS];
	logic [CW-1:0]  cnt_mem [SUBS];
	logic [IdW-1:0] list_mem [LD];
	slot_t          slot_rd_q;
	logic [CW-1:0]  cnt_rd_q;
	logic [IdW-1:0] list_rd_q;

	logic           slot_we, cnt_we, list_we;
	logic [SW-1:0]  waddr;
	slot_t          slot_wd;
	logic [CW-1:0]  cnt_wd;
	logic [LAW-1:0] list_ra, list_wa;

	logic           all_full, slot_end, rng_hit, msk_hit, cand_ok, list_end;
	logic [SW-1:0]  free_idx;
	logic [SubW-1:0] nbest;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = SUBS - 1; i >= 0; i--)
			if (!valid_q[i]) free_idx = SW'(i);
	end
	assign all_full = &valid_q;
	assign slot_end = (ptr_q == SW'(SUBS - 1));

	// filter compares against the current slot
	assign rng_hit = (cur_q.a >= slot_rd_q.low) && (cur_q.a <= slot_rd_q.high);
	assign msk_hit = ((cur_q.a & slot_rd_q.high) == (slot_rd_q.low & slot_rd_q.high));
	assign list_end = ((CW'(j_q) + CW'(1)) >= cnt_rd_q);

	// newest-first selection step
	assign cand_ok = match_q[ptr_q] && (first_q || slot_rd_q.ident < bound_q)
		&& (slot_rd_q.ident > best_q);
	assign nbest = cand_ok ? slot_rd_q.ident : best_q;
	assign lim = (total_q > NW'(MaxResults)) ? NW'(MaxResults) : total_q;

	assign list_ra = LAW'(ptr_q) * LAW'(LIST_MAX) + LAW'(j_q);
	assign list_wa = LAW'(ptr_q) * LAW'(LIST_MAX) + LAW'(cnt_rd_q);

	assign pop = (state_q == S_IDLE) && head.vld;

	// memory write strobes
	always_comb begin
		slot_we = 1'b0;
		cnt_we = 1'b0;
		list_we = 1'b0;
		waddr = ptr_q;
		slot_wd.kind = head.kind;
		slot_wd.low = (head.kind == KIND_LIST) ? '0 : head.a;
		slot_wd.high = (head.kind == KIND_LIST) ? '0 : head.b;
		slot_wd.ident = id_q + SubW'(1);
		cnt_wd = '0;
		if (pop && head.op == OP_SUB && !all_full && id_q != '1) begin
			slot_we = 1'b1;
			cnt_we = 1'b1;
			waddr = free_idx;
		end
		if (state_q == S_APP_DO && cnt_rd_q < CW'(LIST_MAX)) begin
			cnt_we = 1'b1;
			list_we = 1'b1;
			cnt_wd = cnt_rd_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[waddr] <= slot_wd;
		if (cnt_we) cnt_mem[waddr] <= cnt_wd;
		if (list_we) list_mem[list_wa] <= cur_q.a;
		slot_rd_q <= slot_mem[ptr_q];
		cnt_rd_q <= cnt_mem[ptr_q];
		list_rd_q <= list_mem[list_ra];
	end

	// control sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q <= '0;
			valid_q <= '0;
			match_q <= '0;
			id_q <= '0;
			newest_q <= '0;
			ptr_q <= '0;
			j_q <= '0;
			best_q <= '0;
			bound_q <= '0;
			first_q <= 1'b0;
			total_q <= '0;
			sent_q <= '0;
			result_valid <= 1'b0;
			status <= ST_OK;
			is_delivery <= 1'b0;
			sub_number <= '0;
			last <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			is_delivery <= 1'b0;
			sub_number <= '0;
			last <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (head.vld) begin
						cur_q <= head;
						case (head.op)
							OP_SUB: begin
								result_valid <= 1'b1;
								if (all_full) status <= ST_FULL;
								else if (id_q == '1) status <= ST_INVALID;
								else begin
									status <= ST_OK;
									sub_number <= id_q + SubW'(1);
									id_q <= id_q + SubW'(1);
									valid_q[free_idx] <= 1'b1;
									if (head.kind == KIND_LIST)
										newest_q <= {1'b0, free_idx} + (SW+1)'(1);
								end
							end
							OP_APPEND: begin
								if (newest_q == '0 || !valid_q[SW'(newest_q - (SW+1)'(1))]) begin
									result_valid <= 1'b1;
									status <= ST_NOT_FOUND;
								end else begin
									ptr_q <= SW'(newest_q - (SW+1)'(1));
									state_q <= S_APP_WAIT;
								end
							end
							OP_UNSUB: begin
								ptr_q <= '0;
								state_q <= S_UN_WAIT;
							end
							OP_FRAME: begin
								ptr_q <= '0;
								match_q <= '0;
								total_q <= '0;
								state_q <= S_M_WAIT;
							end
							default: begin
								result_valid <= 1'b1;
								status <= ST_INVALID;
							end
						endcase
					end
				end
				S_APP_WAIT: state_q <= S_APP_DO;
				S_APP_DO: begin
					result_valid <= 1'b1;
					status <= (cnt_rd_q < CW'(LIST_MAX)) ? ST_OK : ST_INVALID;
					state_q <= S_IDLE;
				end
				S_UN_WAIT: state_q <= S_UN_CHK;
				S_UN_CHK: begin
					if (valid_q[ptr_q] && slot_rd_q.ident == cur_q.a[SubW-1:0]) begin
						valid_q[ptr_q] <= 1'b0;
						if (newest_q == {1'b0, ptr_q} + (SW+1)'(1)) newest_q <= '0;
						result_valid <= 1'b1;
						status <= ST_OK;
						state_q <= S_IDLE;
					end else if (slot_end) begin
						result_valid <= 1'b1;
						status <= ST_NOT_FOUND;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + SW'(1);
						state_q <= S_UN_WAIT;
					end
				end
				// match pass: one slot at a time, list entries one per step
				S_M_WAIT: state_q <= S_M_CHK;
				S_M_CHK: begin
					if (valid_q[ptr_q] && slot_rd_q.kind == KIND_LIST && cnt_rd_q != '0) begin
						j_q <= '0;
						state_q <= S_L_WAIT;
					end else begin
						if (valid_q[ptr_q] && ((slot_rd_q.kind == KIND_RANGE && rng_hit)
							|| (slot_rd_q.kind == KIND_MASK && msk_hit))) begin
							match_q[ptr_q] <= 1'b1;
							total_q <= total_q + NW'(1);
						end
						ptr_q <= slot_end ? '0 : ptr_q + SW'(1);
						state_q <= slot_end ? S_SEL0 : S_M_WAIT;
					end
				end
				S_L_WAIT: state_q <= S_L_CHK;
				S_L_CHK: begin
					if (list_rd_q == cur_q.a || list_end) begin
						if (list_rd_q == cur_q.a) begin
							match_q[ptr_q] <= 1'b1;
							total_q <= total_q + NW'(1);
						end
						ptr_q <= slot_end ? '0 : ptr_q + SW'(1);
						state_q <= slot_end ? S_SEL0 : S_M_WAIT;
					end else begin
						j_q <= j_q + JW'(1);
						state_q <= S_L_WAIT;
					end
				end
				// report phase: one pass per delivery, highest id below bound
				S_SEL0: begin
					if (match_q == '0) begin
						result_valid <= 1'b1;
						status <= ST_NOT_FOUND;
						state_q <= S_IDLE;
					end else begin
						first_q <= 1'b1;
						best_q <= '0;
						sent_q <= '0;
						ptr_q <= '0;
						state_q <= S_S_WAIT;
					end
				end
				S_S_WAIT: state_q <= S_S_CHK;
				S_S_CHK: begin
					if (slot_end) begin
						result_valid <= 1'b1;
						status <= ST_OK;
						is_delivery <= 1'b1;
						sub_number <= nbest;
						last <= ((sent_q + NW'(1)) == lim);
						bound_q <= nbest;
						first_q <= 1'b0;
						best_q <= '0;
						sent_q <= sent_q + NW'(1);
						ptr_q <= '0;
						state_q <= ((sent_q + NW'(1)) == lim) ? S_IDLE : S_S_WAIT;
					end else begin
						best_q <= nbest;
						ptr_q <= ptr_q + SW'(1);
						state_q <= S_S_WAIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
